/* rtl/sfb_pkg.sv */
package sfb_pkg;

   // action codes of an input item
   localparam logic [1:0] ACT_START = 2'd0;
   localparam logic [1:0] ACT_DATA  = 2'd1;
   localparam logic [1:0] ACT_END   = 2'd2;
   localparam logic [1:0] ACT_NONE  = 2'd3;

   // framing bytes
   localparam logic [7:0] FLAG_BYTE = 8'h7E;
   localparam logic [7:0] ESC_BYTE  = 8'h7D;
   localparam logic [7:0] ESC_FLAG  = 8'h5E;
   localparam logic [7:0] ESC_ESC   = 8'h5D;

   // checksum modulus and header length offset
   localparam int CK_MOD = 45521;
   localparam logic [15:0] LEN_OFFSET = 16'd3;

   // front step indexes
   localparam logic [1:0] STEP_FIRST  = 2'd0;
   localparam logic [1:0] STEP_SECOND = 2'd1;
   localparam logic [1:0] STEP_THIRD  = 2'd2;
   localparam logic [1:0] STEP_FOURTH = 2'd3;

   // one unescaped wire byte handed from front to back
   typedef struct packed {
      logic [7:0] code;
      logic       esc;
      logic       last;
      logic       done;
   } sfb_entry_type;

endpackage

/* rtl/sfb_req_if.sv */
interface sfb_req_if
   import sfb_pkg::*;
   ;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [7:0]  command_code;
   logic [15:0] payload_length;
   logic [7:0]  data_byte;

   modport source (
      output valid, action, command_code, payload_length, data_byte,
      input  ready
   );
   modport sink (
      input  valid, action, command_code, payload_length, data_byte,
      output ready
   );
endinterface

/* rtl/sfb_rsp_if.sv */
interface sfb_rsp_if
   import sfb_pkg::*;
   ;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       last_in_run;
   logic       frame_done;

   modport source (
      output valid, out_byte, last_in_run, frame_done,
      input  ready
   );
   modport sink (
      input  valid, out_byte, last_in_run, frame_done,
      output ready
   );
endinterface

/* rtl/sfb_front.sv */
module sfb_front
   import sfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   sfb_req_if.sink       req_chan,
   output logic          push,
   output sfb_entry_type push_entry,
   input  logic          push_ready
);

   localparam logic signed [17:0] SF_MOD = 18'(CK_MOD);
   localparam logic signed [18:0] SS_MOD = 19'(CK_MOD);

   logic [1:0]  act_ff, act_in;
   logic [7:0]  cmd_ff, cmd_in;
   logic [15:0] len_ff, len_in;
   logic [7:0]  data_ff, data_in;
   logic        busy_ff, busy_in;
   logic [1:0]  step_ff, step_in;
   logic signed [16:0] sf_ff, sf_in;
   logic signed [17:0] ss_ff, ss_in;
   logic        pend_ff, pend_in;

   logic        accept;
   logic        advance;
   logic        last_step;
   logic [7:0]  cur_code;
   logic        cur_sum;
   logic        cur_esc;
   logic        cur_done;
   logic        start_clear;
   logic signed [7:0]  sum_val;
   logic signed [17:0] sf_sum;
   logic signed [17:0] sf_fix;
   logic signed [18:0] ss_sum;
   logic signed [18:0] ss_fix;

   assign accept  = req_chan.valid && req_chan.ready;
   assign advance = busy_ff && push_ready;

   // last byte of the item in hand
   always_comb begin
      case (act_ff)
         ACT_START: last_step = (step_ff == STEP_FOURTH);
         ACT_DATA:  last_step = 1'b1;
         ACT_END:   last_step = (step_ff == STEP_THIRD);
         default:   last_step = 1'b1;
      endcase
   end

   assign req_chan.ready = !busy_ff || (last_step && push_ready);

   // pick the byte for the current step
   always_comb begin
      cur_code = FLAG_BYTE;
      cur_sum  = 1'b0;
      cur_esc  = 1'b0;
      cur_done = 1'b0;
      case (act_ff)
         ACT_START: begin
            case (step_ff)
               STEP_FIRST: begin
                  cur_code = FLAG_BYTE;
               end
               STEP_SECOND: begin
                  cur_code = cmd_ff;
                  cur_sum  = 1'b1;
                  cur_esc  = 1'b1;
               end
               STEP_THIRD: begin
                  cur_code = len_ff[7:0];
                  cur_sum  = 1'b1;
                  cur_esc  = 1'b1;
               end
               default: begin
                  cur_code = len_ff[15:8];
                  cur_sum  = 1'b1;
                  cur_esc  = 1'b1;
               end
            endcase
         end
         ACT_DATA: begin
            cur_code = data_ff;
            cur_sum  = 1'b1;
            cur_esc  = 1'b1;
         end
         ACT_END: begin
            case (step_ff)
               STEP_FIRST: begin
                  cur_code = sf_ff[7:0];
                  cur_esc  = 1'b1;
               end
               STEP_SECOND: begin
                  cur_code = ss_ff[7:0];
                  cur_esc  = 1'b1;
               end
               default: begin
                  cur_code = FLAG_BYTE;
                  cur_done = 1'b1;
               end
            endcase
         end
         default: begin
            cur_code = FLAG_BYTE;
         end
      endcase
   end

   // queue entry, escape decided here
   assign push             = advance;
   assign push_entry.code  = cur_code;
   assign push_entry.esc   = cur_esc && (cur_code == FLAG_BYTE || cur_code == ESC_BYTE);
   assign push_entry.last  = last_step;
   assign push_entry.done  = cur_done;

   // first sum: add signed byte, single correction gives truncating remainder
   assign sum_val = $signed(cur_code);
   assign sf_sum  = {sf_ff[16], sf_ff} + {{10{sum_val[7]}}, sum_val};
   always_comb begin
      if (sf_sum >= SF_MOD) begin
         sf_fix = sf_sum - SF_MOD;
      end else if (sf_sum <= -SF_MOD) begin
         sf_fix = sf_sum + SF_MOD;
      end else begin
         sf_fix = sf_sum;
      end
   end

   // second sum trails the first, adding its new value in the cycle after it changes
   assign ss_sum = {ss_ff[17], ss_ff} + {{2{sf_ff[16]}}, sf_ff};
   always_comb begin
      if (ss_sum >= SS_MOD) begin
         ss_fix = ss_sum - SS_MOD;
      end else if (ss_sum <= -SS_MOD) begin
         ss_fix = ss_sum + SS_MOD;
      end else begin
         ss_fix = ss_sum;
      end
   end

   assign start_clear = advance && (act_ff == ACT_START) && (step_ff == STEP_FIRST);

   // next state
   always_comb begin
      act_in  = act_ff;
      cmd_in  = cmd_ff;
      len_in  = len_ff;
      data_in = data_ff;
      busy_in = busy_ff;
      step_in = step_ff;
      if (accept) begin
         act_in  = req_chan.action;
         cmd_in  = req_chan.command_code;
         len_in  = req_chan.payload_length + LEN_OFFSET;
         data_in = req_chan.data_byte;
         busy_in = (req_chan.action != ACT_NONE);
         step_in = STEP_FIRST;
      end else if (advance) begin
         busy_in = !last_step;
         step_in = step_ff + 2'd1;
      end

      sf_in   = sf_ff;
      ss_in   = pend_ff ? ss_fix[17:0] : ss_ff;
      pend_in = 1'b0;
      if (start_clear) begin
         sf_in = 17'sd1;
         ss_in = 18'sd0;
      end else if (advance && cur_sum) begin
         sf_in   = sf_fix[16:0];
         pend_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         step_ff <= STEP_FIRST;
         sf_ff   <= 17'sd1;
         ss_ff   <= 18'sd0;
         pend_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         step_ff <= step_in;
         sf_ff   <= sf_in;
         ss_ff   <= ss_in;
         pend_ff <= pend_in;
      end
      act_ff  <= act_in;
      cmd_ff  <= cmd_in;
      len_ff  <= len_in;
      data_ff <= data_in;
   end

endmodule

/* rtl/sfb_queue.sv */
module sfb_queue
   import sfb_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          push,
   input  sfb_entry_type push_entry,
   output logic          push_ready,
   output logic          pop_valid,
   output sfb_entry_type pop_entry,
   input  logic          pop
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   sfb_entry_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic do_push;
   logic do_pop;

   assign push_ready = (count_ff != CNT_FULL);
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign do_push    = push && push_ready;
   assign do_pop     = pop && pop_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/sfb_back.sv */
module sfb_back
   import sfb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          pop_valid,
   input  sfb_entry_type pop_entry,
   output logic          pop,
   sfb_rsp_if.source     rsp_chan
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       last_ff, last_in;
   logic       done_ff, done_in;
   logic       second_ff, second_in;
   logic [7:0] second_byte_ff, second_byte_in;
   logic       second_last_ff, second_last_in;
   logic       load;

   // output register free to take a new item
   assign load = !valid_ff || rsp_chan.ready;
   assign pop  = load && !second_ff && pop_valid;

   // escape expansion into the output register
   always_comb begin
      valid_in       = valid_ff;
      byte_in        = byte_ff;
      last_in        = last_ff;
      done_in        = done_ff;
      second_in      = second_ff;
      second_byte_in = second_byte_ff;
      second_last_in = second_last_ff;
      if (load) begin
         if (second_ff) begin
            valid_in  = 1'b1;
            byte_in   = second_byte_ff;
            last_in   = second_last_ff;
            done_in   = 1'b0;
            second_in = 1'b0;
         end else if (pop_valid) begin
            valid_in = 1'b1;
            if (pop_entry.esc) begin
               byte_in        = ESC_BYTE;
               last_in        = 1'b0;
               done_in        = 1'b0;
               second_in      = 1'b1;
               second_byte_in = (pop_entry.code == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
               second_last_in = pop_entry.last;
            end else begin
               byte_in = pop_entry.code;
               last_in = pop_entry.last;
               done_in = pop_entry.done;
            end
         end else begin
            valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff  <= 1'b0;
         second_ff <= 1'b0;
      end else begin
         valid_ff  <= valid_in;
         second_ff <= second_in;
      end
      byte_ff        <= byte_in;
      last_ff        <= last_in;
      done_ff        <= done_in;
      second_byte_ff <= second_byte_in;
      second_last_ff <= second_last_in;
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.out_byte    = byte_ff;
   assign rsp_chan.last_in_run = last_ff;
   assign rsp_chan.frame_done  = done_ff;

endmodule

/* rtl/stuffed_frame_builder_unit.sv */
// an accepted item passes the front register, a queue slot, then the output register
// throughput: front takes a payload item every cycle while the queue has room; a start
// item gives flag, command and length bytes, an end both sums and the flag; back sends one wire
// byte a cycle while ready, escaped bytes as prefix and code; output register sets the rate
// reset: synchronous, clears queue, handshake state and the checksum to 1 and 0
module stuffed_frame_builder_unit
   import sfb_pkg::*;
#(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic       clock,
   input  logic       reset,
   sfb_req_if.sink    req_chan,
   sfb_rsp_if.source  rsp_chan
);

   logic          push;
   sfb_entry_type push_entry;
   logic          push_ready;
   logic          pop_valid;
   sfb_entry_type pop_entry;
   logic          pop;

   // front: takes items, sums and sequences unescaped bytes
   sfb_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   // short queue between front and back
   sfb_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop        (pop)
   );

   // back: escaping and output register
   sfb_back u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop       (pop),
      .rsp_chan  (rsp_chan)
   );

   // closing flag is a raw flag and ends its item
   a_done_is_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.frame_done |->
         rsp_chan.last_in_run && rsp_chan.out_byte == FLAG_BYTE)
      else $error("frame_done on a byte other than the closing flag");

   // an escape prefix is followed at once by its escaped code
   a_escape_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.ready && rsp_chan.out_byte == ESC_BYTE |=>
         rsp_chan.valid && (rsp_chan.out_byte == ESC_FLAG || rsp_chan.out_byte == ESC_ESC))
      else $error("escape prefix not followed by its code");

   // an escape prefix never ends an item
   a_escape_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_chan.valid && rsp_chan.out_byte == ESC_BYTE |-> !rsp_chan.last_in_run)
      else $error("escape prefix marked as last byte");

   // nothing is shown right after reset
   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_chan.valid)
      else $error("result shown after reset");

endmodule
